// ----- src/bsst_pkg.sv -----
// Shared constants and types for the binary search sorted table block.
`default_nettype none

package bsst_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_W     = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;

	// Stream payload widths (fields packed from bit 0, padded to whole bytes)
	localparam int S_FIELD_W = IDX_W + 2 * VALUE_W;
	localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((IDX_W + 7) / 8) * 8;

	// APB port geometry
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register index of entry_count (selected by paddr[2])
	localparam logic REG_ENTRY_COUNT = 1'b0;

	// Item kinds carried on s_tuser
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CNT_W-1:0]          cnt_t;

endpackage

`default_nettype wire

// ----- src/bsst_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- src/binary_search_sorted_table.sv -----
// Top level: sorted table in RAM with a probe sequencer for binary search.
// A load transaction (s_tuser = 0) writes one table entry and gives no
// result. A search transaction (s_tuser = 1) probes the first entry_count
// entries by floor midpoint and returns one result with found on m_tuser and
// the matching index on m_tdata (zero when not found). Each probe reads the
// table RAM in the probe state and compares the read value with the key in
// the compare state. A search makes at most 11 probes for a full 1024-entry
// table. s_tready stays low while a search runs. A finished result sits in
// an output register, so the next item is accepted while it waits; a
// following search holds its result until that register drains. Table
// contents are undefined after reset: load every entry below entry_count
// before searching. entry_count is written over APB at byte address 0 from
// pwdata[10:0]; values above 1024 are treated as 1024.
`default_nettype none

module binary_search_sorted_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [9:0] entry_index, [41:10] entry_value, [73:42] search_key, rest zero
	input  wire logic [bsst_pkg::S_DATA_W-1:0]  s_tdata,
	// [0] action
	input  wire logic                           s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [9:0] position, rest zero
	output logic      [bsst_pkg::M_DATA_W-1:0]  m_tdata,
	// [0] found
	output logic                                m_tuser,
	// APB configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [bsst_pkg::APB_AW-1:0]    paddr,
	input  wire logic [bsst_pkg::APB_DW-1:0]    pwdata,
	output logic      [bsst_pkg::APB_DW-1:0]    prdata,
	output logic                                pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;

	localparam int IW = bsst_pkg::IDX_W;
	localparam int CW = bsst_pkg::CNT_W;
	localparam int VW = bsst_pkg::VALUE_W;

	logic [1:0]            state_q;
	bsst_pkg::cnt_t        entry_count_q;
	bsst_pkg::cnt_t        count_sat;
	bsst_pkg::cnt_t        lo_q;
	bsst_pkg::cnt_t        hi_q;        // exclusive upper bound
	bsst_pkg::idx_t        mid_q;
	bsst_pkg::idx_t        mid;
	logic [CW:0]           mid_sum;
	bsst_pkg::value_t      key_q;
	bsst_pkg::value_t      probe_val;
	logic [VW-1:0]         rd_data;
	logic                  in_range;
	logic                  s_xfer;
	logic                  load_wr;
	logic                  rd_en;
	logic                  out_free;
	logic                  fin;
	logic                  fin_found;
	logic                  cfg_wr;
	logic                  m_tvalid_q;
	logic                  found_q;
	bsst_pkg::idx_t        pos_q;

	bsst_pkg::idx_t        in_index;
	bsst_pkg::value_t      in_value;
	bsst_pkg::value_t      in_key;

	assign in_index = s_tdata[IW-1:0];
	assign in_value = s_tdata[IW+VW-1:IW];
	assign in_key   = s_tdata[IW+2*VW-1:IW+VW];

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bsst_pkg::REG_ENTRY_COUNT);
	assign prdata = (paddr[2] == bsst_pkg::REG_ENTRY_COUNT)
		? {{(bsst_pkg::APB_DW-CW){1'b0}}, entry_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr) begin
			entry_count_q <= pwdata[CW-1:0];
		end
	end

	assign count_sat = (entry_count_q > CW'(bsst_pkg::TABLE_DEPTH))
		? CW'(bsst_pkg::TABLE_DEPTH) : entry_count_q;

	// input handshake
	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign load_wr  = s_xfer && (s_tuser == bsst_pkg::ACT_LOAD);

	// floor midpoint of lo and (hi - 1)
	assign in_range = (lo_q < hi_q);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q} - (CW+1)'(1);
	assign mid      = mid_sum[IW:1];
	assign rd_en    = (state_q == ST_PROBE) && in_range;

	bsst_ram #(
		.WIDTH (VW),
		.DEPTH (bsst_pkg::TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (load_wr),
		.wr_addr (in_index),
		.wr_data (in_value),
		.rd_en   (rd_en),
		.rd_addr (mid),
		.rd_data (rd_data)
	);

	assign probe_val = $signed(rd_data);

	// a result can be written when the output register is empty or draining
	assign out_free  = !m_tvalid_q || m_tready;
	assign fin_found = (state_q == ST_CMP) && (probe_val == key_q);
	assign fin       = out_free &&
		(fin_found || ((state_q == ST_PROBE) && !in_range));

	// probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lo_q    <= '0;
			hi_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer && (s_tuser == bsst_pkg::ACT_SEARCH)) begin
						lo_q    <= '0;
						hi_q    <= count_sat;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (in_range) begin
						state_q <= ST_CMP;
					end else if (fin) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					if (probe_val == key_q) begin
						if (fin) begin
							state_q <= ST_IDLE;
						end
					end else if (probe_val < key_q) begin
						lo_q    <= {1'b0, mid_q} + CW'(1);
						state_q <= ST_PROBE;
					end else begin
						hi_q    <= {1'b0, mid_q};
						state_q <= ST_PROBE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search payload registers
	always_ff @(posedge clk) begin
		if (s_xfer && (s_tuser == bsst_pkg::ACT_SEARCH)) begin
			key_q <= in_key;
		end
		if (rd_en) begin
			mid_q <= mid;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			found_q <= fin_found;
			pos_q   <= fin_found ? mid_q : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = {{(bsst_pkg::M_DATA_W-IW){1'b0}}, pos_q};

endmodule

`default_nettype wire

// ----- src/bsst_checker.sv -----
// Port-level checks for the binary search sorted table, bound to the top level.
`default_nettype none

module bsst_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [bsst_pkg::S_DATA_W-1:0]  s_tdata,
	input wire logic                           s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [bsst_pkg::M_DATA_W-1:0]  m_tdata,
	input wire logic                           m_tuser
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a miss reports position zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero position");

	// a load transaction never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == bsst_pkg::ACT_LOAD) && !m_tvalid |=> !m_tvalid)
		else $error("result after a load transaction");

	// a search passes through the probe state before its result appears
	a_search_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == bsst_pkg::ACT_SEARCH) && !m_tvalid |=> !m_tvalid)
		else $error("search result too early");

	// input is blocked while a search runs
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == bsst_pkg::ACT_SEARCH) |=> !s_tready)
		else $error("input accepted during a search");

endmodule

bind binary_search_sorted_table bsst_checker u_bsst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
